// ----- design/ab3_pkg.sv -----
// ----------------------------------------------------------------------------
// ab3_pkg
// Shared widths, codes, types and the helper function of the third-order
// Adams-Bashforth integrator core.
// ----------------------------------------------------------------------------
package ab3_pkg;

    // Number of state elements that keep a derivative history.
    localparam int MAX_ELEMENTS = 16;
    localparam int HIST_AW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    // Field widths.
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 32;
    localparam int TIME_W     = 48;
    localparam int STEP_W     = 31;
    localparam int FRAC_W     = 16;
    localparam int VLEN_W     = 5;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Datapath widths.
    localparam int SUM_W      = 39;                 // weighted derivative sum
    localparam int PROD_LO_W  = 56;                 // sum times low half of h
    localparam int PROD_HI_W  = 55;                 // sum times high half of h
    localparam int CLAMP_EXP  = 34;                 // increment clamp is 2^34
    localparam int INC_W      = CLAMP_EXP + 2;      // clamped increment, signed
    localparam int RES_W      = INC_W + 1;          // value plus increment
    localparam int DIV3_W     = 40;                 // dividend of the divide by 3
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_PER_STAGE = DIV3_W / (2 * DIGIT_W);
    localparam int HALF_DIV3_W      = DIV3_W / 2;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
    localparam logic [VLEN_W-1:0]  VLEN_RESET = VLEN_W'(1);

    // Phase counter values that select the integration formula.
    localparam logic [PHASE_W-1:0] PHASE_EULER        = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PHASE_AB2          = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PHASE_AB3_Q_FIRST  = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] PHASE_AB3_Q_LAST   = PHASE_W'(4);
    localparam logic [PHASE_W-1:0] PHASE_AB3_H_FIRST  = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PHASE_AB3_H_LAST   = PHASE_W'(6);
    localparam logic [PHASE_W-1:0] PHASE_FINAL        = PHASE_W'(8);

    // Saturation bounds of a result value.
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LEN      = 1'b0,
        CFG_VECTOR_LENGTH = 1'b1
    } t_cfg_reg;

    // Constant divisor applied to h * S / 65536.
    typedef enum logic [2:0] {
        DIV_4,
        DIV_8,
        DIV_12,
        DIV_24,
        DIV_48
    } t_divisor;

    // One history entry: two full-step and two quarter-step derivative slots.
    typedef struct packed {
        logic [VALUE_W-1:0] full_recent;
        logic [VALUE_W-1:0] full_older;
        logic [VALUE_W-1:0] quarter_recent;
        logic [VALUE_W-1:0] quarter_older;
    } t_hist_word;

    // Accepted input item together with the phase it belongs to.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] derivative;
        logic [TIME_W-1:0]  cur_time;
        logic               last;
        logic [PHASE_W-1:0] phase;
    } t_in_item;

    // Fields that ride along the arithmetic pipeline.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  next_time;
        logic               last;
        logic               in_range;
    } t_carry;

    // One radix-16 step of an unsigned divide by three.
    typedef struct packed {
        logic [DIGIT_W-1:0] quot;
        logic [1:0]         rem;
    } t_div3_digit;

    // Partial remainder and one hex digit in, quotient digit and remainder out.
    // The partial dividend is at most 47, where t * 43 / 128 equals t / 3.
    function automatic t_div3_digit div3_digit(input logic [1:0] rem_in,
                                               input logic [DIGIT_W-1:0] digit);
        t_div3_digit res;
        logic [5:0]  part;
        logic [11:0] scaled;
        logic [5:0]  three_q;
        part    = {rem_in, digit};
        scaled  = 12'(part) * 12'd43;
        res.quot = scaled[10:7];
        three_q = {1'b0, res.quot, 1'b0} + {2'b00, res.quot};
        res.rem = 2'(part - three_q);
        return res;
    endfunction

endpackage

// ----- design/adams_bashforth3_integrator_core.sv -----
// ----------------------------------------------------------------------------
// adams_bashforth3_integrator_core
// Fixed-step third-order Adams-Bashforth integrator with a quarter-step and
// half-step starter, derivative history held in a per-element memory.
// ----------------------------------------------------------------------------
//
// Usage
// The input channel carries one state element per transfer: its index, value,
// derivative, the current time and a marker on the last element of a vector.
// Each input transfer yields exactly one output transfer with the integrated
// value, the advanced time, the index and the marker, in order. The phase
// counter moves on the transfer marked last and selects Euler, AB2 and AB3 at
// quarter step, AB3 at half step, and then AB3 at full step.
// The configuration channel writes the step length h (index 0) and
// vector_length (index 1); it is always ready and should only be used while
// the core idles.
// Throughput is one element per cycle unless the receiver stalls, set by the
// history memory: each element costs one read port access at input time and
// one write-back when it moves on to stage 2, with the write forwarded to an
// element read in the same cycle. Elements at or beyond vector_length leave
// the history untouched. Reset sets the step length to 1.0, vector_length to
// 1 and the phase to one, and empties the pipeline. When the receiver stalls,
// the result waits in the output register and the stages behind it keep
// filling their bubbles; input ready drops only once every stage holds an
// element.
//
module adams_bashforth3_integrator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input element channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ab3_pkg::INDEX_W-1:0]      i_element_index,
    input  logic signed [ab3_pkg::VALUE_W-1:0] i_state_value,
    input  logic signed [ab3_pkg::VALUE_W-1:0] i_state_derivative,
    input  logic [ab3_pkg::TIME_W-1:0]       i_current_time,
    input  logic                             i_last_element,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ab3_pkg::INDEX_W-1:0]      o_out_index,
    output logic signed [ab3_pkg::VALUE_W-1:0] o_next_value,
    output logic [ab3_pkg::TIME_W-1:0]       o_next_time,
    output logic                             o_out_last,
    output logic                             o_saturated,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ab3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ab3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ab3_pkg::*;

    // Number of registered stages ahead of the output register.
    localparam int NUM_STAGES = 6;

    localparam logic signed [PROD_LO_W-1:0] CLAMP_HI = PROD_LO_W'(1) << CLAMP_EXP;
    localparam logic signed [PROD_LO_W-1:0] CLAMP_LO = -CLAMP_HI;
    // Bias that lifts the clamped quotient input above zero before dividing.
    localparam logic [DIV3_W-1:0]   DIV3_BIAS  = DIV3_W'(3) << CLAMP_EXP;
    localparam logic [INC_W-1:0]    QUOT_BIAS  = INC_W'(1) << CLAMP_EXP;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(VALUE_MAX);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(VALUE_MIN);

    // ------------------------------------------------------------------
    // Configuration registers and phase counter
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]  r_step_len;
    logic [VLEN_W-1:0]  r_vector_length;
    logic [PHASE_W-1:0] r_phase;

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    // w_en[k] is high when stage k may load; the output register is k = 7.
    logic [NUM_STAGES:1]   r_valid;
    logic                  r_out_valid;
    logic [NUM_STAGES+1:1] w_en;
    logic                  w_accept;

    always_comb begin
        w_en[NUM_STAGES+1] = !r_out_valid || i_out_ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[1];
    assign w_accept    = i_in_valid && w_en[1];
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en[1]) begin
                r_valid[1] <= w_accept;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
            if (w_en[NUM_STAGES+1]) begin
                r_out_valid <= r_valid[NUM_STAGES];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_len      <= STEP_RESET;
            r_vector_length <= VLEN_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_STEP_LEN:      r_step_len      <= i_cfg_data[STEP_W-1:0];
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[VLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The phase seen by an element is the one current when it is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_EULER;
        end else if (w_accept && i_last_element && (r_phase < PHASE_FINAL)) begin
            r_phase <= r_phase + PHASE_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: history memory read, forwarding, weighted sum, write-back
    // ------------------------------------------------------------------
    t_hist_word           mem_hist [MAX_ELEMENTS];
    t_hist_word           r_mem_rd;
    t_in_item             r_s1;
    logic                 r_fwd_valid;
    logic [HIST_AW-1:0]   r_fwd_addr;
    t_hist_word           r_fwd_data;

    logic [HIST_AW-1:0]   w_rd_addr;
    logic [HIST_AW-1:0]   w_wr_addr;
    logic                 w_wr_en;
    t_hist_word           w_hist;
    t_hist_word           w_new_word;
    logic                 w_in_range;
    logic signed [SUM_W-1:0] w_yp;
    logic signed [SUM_W-1:0] w_qr;
    logic signed [SUM_W-1:0] w_qo;
    logic signed [SUM_W-1:0] w_fr;
    logic signed [SUM_W-1:0] w_fo;
    logic signed [SUM_W-1:0] w_ab2;
    logic signed [SUM_W-1:0] w_ab3_quarter;
    logic signed [SUM_W-1:0] w_ab3_full;
    logic signed [SUM_W-1:0] w_sum;
    t_divisor             w_div;
    logic [TIME_W-1:0]    w_dt;
    t_carry               w_carry;

    assign w_rd_addr = HIST_AW'(i_element_index);
    assign w_wr_addr = HIST_AW'(r_s1.index);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_hist[w_wr_addr] <= w_new_word;
        end
        if (w_accept) begin
            r_mem_rd <= mem_hist[w_rd_addr];
            r_s1     <= '{index:      i_element_index,
                          value:      i_state_value,
                          derivative: i_state_derivative,
                          cur_time:   i_current_time,
                          last:       i_last_element,
                          phase:      r_phase};
        end
    end

    // The element read at an accepting edge misses the write-back made at the
    // same edge; that write is kept here and used in place of the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_accept) begin
            r_fwd_valid <= w_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd_addr <= w_wr_addr;
            r_fwd_data <= w_new_word;
        end
    end

    assign w_hist = (r_fwd_valid && (r_fwd_addr == w_wr_addr)) ? r_fwd_data : r_mem_rd;

    assign w_in_range = ({1'b0, r_s1.index} < r_vector_length)
                        && (int'(r_s1.index) < MAX_ELEMENTS);
    assign w_wr_en    = r_valid[1] && w_en[2] && w_in_range;

    assign w_yp = {{(SUM_W-VALUE_W){r_s1.derivative[VALUE_W-1]}}, r_s1.derivative};
    assign w_qr = {{(SUM_W-VALUE_W){w_hist.quarter_recent[VALUE_W-1]}},
                   w_hist.quarter_recent};
    assign w_qo = {{(SUM_W-VALUE_W){w_hist.quarter_older[VALUE_W-1]}},
                   w_hist.quarter_older};
    assign w_fr = {{(SUM_W-VALUE_W){w_hist.full_recent[VALUE_W-1]}},
                   w_hist.full_recent};
    assign w_fo = {{(SUM_W-VALUE_W){w_hist.full_older[VALUE_W-1]}},
                   w_hist.full_older};

    assign w_ab2         = 39'sd3 * w_yp - w_qo;
    assign w_ab3_quarter = 39'sd23 * w_yp - 39'sd16 * w_qr + 39'sd5 * w_qo;
    assign w_ab3_full    = 39'sd23 * w_yp - 39'sd16 * w_fr + 39'sd5 * w_fo;

    always_comb begin
        w_new_word = w_hist;
        w_sum      = w_ab3_full;
        w_div      = DIV_12;
        w_dt       = TIME_W'(r_step_len);
        case (r_s1.phase)
            PHASE_EULER: begin
                w_sum                    = w_yp;
                w_div                    = DIV_4;
                w_dt                     = TIME_W'(r_step_len >> 2);
                w_new_word.full_older    = r_s1.derivative;
                w_new_word.quarter_older = r_s1.derivative;
            end
            PHASE_AB2: begin
                w_sum                     = w_ab2;
                w_div                     = DIV_8;
                w_dt                      = TIME_W'(r_step_len >> 2);
                w_new_word.quarter_recent = r_s1.derivative;
            end
            PHASE_AB3_Q_FIRST: begin
                w_sum                     = w_ab3_quarter;
                w_div                     = DIV_48;
                w_dt                      = TIME_W'(r_step_len >> 2);
                w_new_word.quarter_older  = w_hist.quarter_recent;
                w_new_word.quarter_recent = r_s1.derivative;
            end
            PHASE_AB3_Q_LAST: begin
                // The quarter-step chain restarts from the first full-step slot.
                w_sum                    = w_ab3_quarter;
                w_div                    = DIV_48;
                w_dt                     = TIME_W'(r_step_len >> 2);
                w_new_word.quarter_older = w_hist.full_older;
            end
            PHASE_AB3_H_FIRST: begin
                w_sum                     = w_ab3_quarter;
                w_div                     = DIV_24;
                w_dt                      = TIME_W'(r_step_len >> 1);
                w_new_word.full_recent    = r_s1.derivative;
                w_new_word.quarter_older  = w_hist.quarter_recent;
                w_new_word.quarter_recent = r_s1.derivative;
            end
            PHASE_AB3_H_LAST: begin
                w_sum                     = w_ab3_quarter;
                w_div                     = DIV_24;
                w_dt                      = TIME_W'(r_step_len >> 1);
                w_new_word.quarter_older  = w_hist.quarter_recent;
                w_new_word.quarter_recent = r_s1.derivative;
            end
            default: begin
                w_new_word.full_older  = w_hist.full_recent;
                w_new_word.full_recent = r_s1.derivative;
            end
        endcase
    end

    assign w_carry = '{index:     r_s1.index,
                       value:     r_s1.value,
                       next_time: r_s1.cur_time + w_dt,
                       last:      r_s1.last,
                       in_range:  w_in_range};

    // ------------------------------------------------------------------
    // Stage 2: sum times step length, as two partial products
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]     r_s2_sum;
    t_divisor                    r_s2_div;
    t_carry                      r_s2_carry;
    logic signed [PROD_LO_W-1:0] w_prod_lo;
    logic signed [PROD_HI_W-1:0] w_prod_hi;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_sum   <= w_sum;
            r_s2_div   <= w_div;
            r_s2_carry <= w_carry;
        end
    end

    assign w_prod_lo = r_s2_sum * $signed({1'b0, r_step_len[FRAC_W-1:0]});
    assign w_prod_hi = r_s2_sum * $signed({1'b0, r_step_len[STEP_W-1:FRAC_W]});

    // ------------------------------------------------------------------
    // Stage 3: floor(h * S / 65536) >> log2 of the power-of-two factor,
    // clamped to a range that already saturates every result
    // ------------------------------------------------------------------
    logic signed [PROD_LO_W-1:0] r_s3_lo;
    logic signed [PROD_HI_W-1:0] r_s3_hi;
    t_divisor                    r_s3_div;
    t_carry                      r_s3_carry;
    logic signed [PROD_LO_W-1:0] w_base;
    logic signed [PROD_LO_W-1:0] w_shifted;
    logic signed [PROD_LO_W-1:0] w_clamped;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_lo    <= w_prod_lo;
            r_s3_hi    <= w_prod_hi;
            r_s3_div   <= r_s2_div;
            r_s3_carry <= r_s2_carry;
        end
    end

    assign w_base = PROD_LO_W'(r_s3_hi) + (r_s3_lo >>> FRAC_W);

    always_comb begin
        case (r_s3_div)
            DIV_4, DIV_12: w_shifted = w_base >>> 2;
            DIV_8, DIV_24: w_shifted = w_base >>> 3;
            DIV_48:        w_shifted = w_base >>> 4;
            default:       w_shifted = w_base >>> 4;
        endcase
        if (w_shifted > CLAMP_HI) begin
            w_clamped = CLAMP_HI;
        end else if (w_shifted < CLAMP_LO) begin
            w_clamped = CLAMP_LO;
        end else begin
            w_clamped = w_shifted;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: bias to a positive dividend, upper half of the divide by 3
    // ------------------------------------------------------------------
    logic signed [INC_W-1:0]   r_s4_x;
    t_divisor                  r_s4_div;
    t_carry                    r_s4_carry;
    logic [DIV3_W-1:0]         w_dividend;
    logic [HALF_DIV3_W-1:0]    w_quot_hi;
    logic [1:0]                w_rem_hi;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_x     <= INC_W'(w_clamped);
            r_s4_div   <= r_s3_div;
            r_s4_carry <= r_s3_carry;
        end
    end

    assign w_dividend = DIV3_W'(r_s4_x) + DIV3_BIAS;

    always_comb begin
        t_div3_digit step;
        w_rem_hi = 2'b00;
        for (int i = 0; i < DIGITS_PER_STAGE; i++) begin
            step = div3_digit(w_rem_hi, w_dividend[DIV3_W-1-DIGIT_W*i -: DIGIT_W]);
            w_quot_hi[HALF_DIV3_W-1-DIGIT_W*i -: DIGIT_W] = step.quot;
            w_rem_hi = step.rem;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: lower half of the divide by 3, increment selection
    // ------------------------------------------------------------------
    logic [HALF_DIV3_W-1:0]  r_s5_quot_hi;
    logic [1:0]              r_s5_rem;
    logic [HALF_DIV3_W-1:0]  r_s5_low;
    logic signed [INC_W-1:0] r_s5_x;
    logic                    r_s5_div3;
    t_carry                  r_s5_carry;
    logic [HALF_DIV3_W-1:0]  w_quot_lo;
    logic [1:0]              w_rem_lo;
    logic [DIV3_W-1:0]       w_quot;
    logic signed [INC_W-1:0] w_inc;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_quot_hi <= w_quot_hi;
            r_s5_rem     <= w_rem_hi;
            r_s5_low     <= w_dividend[HALF_DIV3_W-1:0];
            r_s5_x       <= r_s4_x;
            r_s5_div3    <= (r_s4_div == DIV_12) || (r_s4_div == DIV_24)
                            || (r_s4_div == DIV_48);
            r_s5_carry   <= r_s4_carry;
        end
    end

    always_comb begin
        t_div3_digit step;
        w_rem_lo = r_s5_rem;
        for (int i = 0; i < DIGITS_PER_STAGE; i++) begin
            step = div3_digit(w_rem_lo, r_s5_low[HALF_DIV3_W-1-DIGIT_W*i -: DIGIT_W]);
            w_quot_lo[HALF_DIV3_W-1-DIGIT_W*i -: DIGIT_W] = step.quot;
            w_rem_lo = step.rem;
        end
    end

    assign w_quot = {r_s5_quot_hi, w_quot_lo};
    // Removing the bias: (x + 3 * 2^34) / 3 - 2^34 is floor(x / 3).
    assign w_inc  = r_s5_div3 ? $signed(INC_W'(w_quot) - QUOT_BIAS) : r_s5_x;

    // ------------------------------------------------------------------
    // Stage 6: add to the state value and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [INC_W-1:0]   r_s6_inc;
    t_carry                    r_s6_carry;
    logic signed [RES_W-1:0]   w_total;
    logic signed [VALUE_W-1:0] w_result;
    logic                      w_clip;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_inc   <= w_inc;
            r_s6_carry <= r_s5_carry;
        end
    end

    assign w_total = RES_W'($signed(r_s6_carry.value)) + RES_W'(r_s6_inc);

    always_comb begin
        if (!r_s6_carry.in_range) begin
            w_result = $signed(r_s6_carry.value);
            w_clip   = 1'b0;
        end else if (w_total > RES_MAX) begin
            w_result = VALUE_MAX;
            w_clip   = 1'b1;
        end else if (w_total < RES_MIN) begin
            w_result = VALUE_MIN;
            w_clip   = 1'b1;
        end else begin
            w_result = VALUE_W'(w_total);
            w_clip   = 1'b0;
        end
    end

    logic [INDEX_W-1:0]        r_out_index;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [TIME_W-1:0]         r_out_time;
    logic                      r_out_last;
    logic                      r_out_sat;

    always_ff @(posedge i_clk) begin
        if (w_en[NUM_STAGES+1]) begin
            r_out_index <= r_s6_carry.index;
            r_out_value <= w_result;
            r_out_time  <= r_s6_carry.next_time;
            r_out_last  <= r_s6_carry.last;
            r_out_sat   <= w_clip;
        end
    end

    assign o_out_index  = r_out_index;
    assign o_next_value = r_out_value;
    assign o_next_time  = r_out_time;
    assign o_out_last   = r_out_last;
    assign o_saturated  = r_out_sat;

endmodule

// ----- design/ab3_checker.sv -----
// ----------------------------------------------------------------------------
// ab3_checker
// Port-level checks of the integrator core's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module ab3_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [ab3_pkg::INDEX_W-1:0]        o_out_index,
    input logic signed [ab3_pkg::VALUE_W-1:0] o_next_value,
    input logic [ab3_pkg::TIME_W-1:0]         o_next_time,
    input logic                               o_out_last,
    input logic                               o_saturated
);
    import ab3_pkg::*;

    // Reset empties the pipeline, so no result is offered right after it.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A clipped result carries one of the two range limits.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated
        |-> (o_next_value == VALUE_MAX) || (o_next_value == VALUE_MIN))
        else $error("saturated flag without a limit value");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before its transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready
        |=> $stable(o_out_index) && $stable(o_next_value) && $stable(o_next_time)
            && $stable(o_out_last) && $stable(o_saturated))
        else $error("result changed while stalled");

endmodule

bind adams_bashforth3_integrator_core ab3_checker u_ab3_checker (.*);

// ----- dv/tb_adams_bashforth3_integrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adams_bashforth3_integrator_core
// Self-checking bench for the third-order Adams-Bashforth integrator core.
// A behavioral predictor tracks the phase counter, the step registers and the
// per-element derivative history, and each result transfer is compared field
// by field with the oldest prediction. The bench walks the core through the
// whole starter (Euler, AB2, AB3 at quarter and half step), then hits value
// extremes and runs randomized vectors under changing step lengths and vector
// lengths, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_adams_bashforth3_integrator_core;
    import ab3_pkg::*;

    localparam int CYCLE_LIMIT    = 600_000;
    localparam int ITEM_TARGET    = 900;
    localparam int DRAIN_CYCLES   = 8;     // extra wait once every result is back

    // Clock, reset and every DUT input start at a known value.
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       in_valid    = 1'b0;
    logic [INDEX_W-1:0]         in_index    = '0;
    logic [VALUE_W-1:0]         in_value    = '0;
    logic [VALUE_W-1:0]         in_deriv    = '0;
    logic [TIME_W-1:0]          in_time     = '0;
    logic                       in_last     = 1'b0;
    logic                       out_ready   = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = CFG_STEP_LEN;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;

    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [INDEX_W-1:0]         o_out_index;
    logic signed [VALUE_W-1:0]  o_next_value;
    logic [TIME_W-1:0]          o_next_time;
    logic                       o_out_last;
    logic                       o_saturated;
    logic                       o_cfg_ready;

    // One predicted result transfer.
    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic [TIME_W-1:0]         ntime;
        logic                      last;
        logic                      sat;
    } t_predicted_state;

    t_predicted_state predicted_states[$];

    // Predictor copy of the configuration registers and of the core state.
    logic [STEP_W-1:0]          cur_step = STEP_RESET;
    logic [VLEN_W-1:0]          cur_vlen = VLEN_RESET;
    logic [PHASE_W-1:0]         formula_phase = PHASE_EULER;
    logic signed [VALUE_W-1:0]  deriv_full_new    [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0]  deriv_full_old    [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0]  deriv_quarter_new [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0]  deriv_quarter_old [MAX_ELEMENTS];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    bit  src_steady     = 1'b0;    // input side sends back to back when set
    bit  sink_steady    = 1'b0;    // output side never stalls when set

    adams_bashforth3_integrator_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_element_index    (in_index),
        .i_state_value      (in_value),
        .i_state_derivative (in_deriv),
        .i_current_time     (in_time),
        .i_last_element     (in_last),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_out_index        (o_out_index),
        .o_next_value       (o_next_value),
        .o_next_time        (o_next_time),
        .o_out_last         (o_out_last),
        .o_saturated        (o_saturated),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("adams_bashforth3_integrator_core verification failed");
            $finish;
        end
    end

    // Idle or stall length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output back-pressure. Ready goes high for one cycle, then a random stall
    // follows unless the sink is in its steady mode.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            hold_left <= sink_steady ? 0 : idle_len();
        end
    end

    // Predictor for one accepted element. It picks the formula from the phase
    // counter, reads the history before updating it, and forms the increment
    // floor(h * S / (65536 * D)) exactly in wide signed arithmetic.
    function automatic t_predicted_state integrate_item(
        input logic [INDEX_W-1:0]        idx,
        input logic signed [VALUE_W-1:0] y,
        input logic signed [VALUE_W-1:0] yp,
        input logic [TIME_W-1:0]         t,
        input logic                      last
    );
        t_predicted_state   r;
        logic [TIME_W-1:0]  dt;
        longint             wsum;
        longint             divisor;
        longint             nxt;
        logic signed [95:0] h_wide;
        logic signed [95:0] s_wide;
        logic signed [95:0] num;
        logic signed [95:0] den;
        logic signed [95:0] quo;
        logic signed [VALUE_W-1:0] qn, qo, fn, fo;

        if (formula_phase <= PHASE_AB3_Q_LAST)
            dt = TIME_W'(cur_step >> 2);
        else if (formula_phase <= PHASE_AB3_H_LAST)
            dt = TIME_W'(cur_step >> 1);
        else
            dt = TIME_W'(cur_step);

        nxt   = longint'(y);
        r.sat = 1'b0;

        // Elements beyond the vector length pass through and leave the
        // history alone.
        if ({1'b0, idx} < cur_vlen) begin
            qn = deriv_quarter_new[idx];
            qo = deriv_quarter_old[idx];
            fn = deriv_full_new[idx];
            fo = deriv_full_old[idx];
            if (formula_phase == PHASE_EULER) begin
                wsum    = longint'(yp);
                divisor = 4;
                deriv_full_old[idx]    = yp;
                deriv_quarter_old[idx] = yp;
            end else if (formula_phase == PHASE_AB2) begin
                wsum    = 3 * longint'(yp) - longint'(qo);
                divisor = 8;
                deriv_quarter_new[idx] = yp;
            end else if (formula_phase <= PHASE_AB3_Q_LAST) begin
                wsum    = 23 * longint'(yp) - 16 * longint'(qn) + 5 * longint'(qo);
                divisor = 48;
                if (formula_phase == PHASE_AB3_Q_FIRST) begin
                    deriv_quarter_old[idx] = qn;
                    deriv_quarter_new[idx] = yp;
                end else begin
                    // Second quarter AB3 step: the half-step history starts
                    // from the derivative saved at the Euler step.
                    deriv_quarter_old[idx] = fo;
                end
            end else if (formula_phase <= PHASE_AB3_H_LAST) begin
                wsum    = 23 * longint'(yp) - 16 * longint'(qn) + 5 * longint'(qo);
                divisor = 24;
                if (formula_phase == PHASE_AB3_H_FIRST)
                    deriv_full_new[idx] = yp;
                deriv_quarter_old[idx] = qn;
                deriv_quarter_new[idx] = yp;
            end else begin
                wsum    = 23 * longint'(yp) - 16 * longint'(fn) + 5 * longint'(fo);
                divisor = 12;
                deriv_full_old[idx] = fn;
                deriv_full_new[idx] = yp;
            end

            h_wide = 96'(cur_step);
            s_wide = wsum;
            num    = h_wide * s_wide;
            den    = 96'(divisor) << FRAC_W;
            quo    = num / den;
            // Division truncates toward zero; step down for negative inexact.
            if (num < 0 && quo * den != num)
                quo = quo - 1;
            nxt = longint'(y) + longint'(quo);

            if (nxt > 64'sd2147483647) begin
                nxt   = 64'sd2147483647;
                r.sat = 1'b1;
            end else if (nxt < -64'sd2147483648) begin
                nxt   = -64'sd2147483648;
                r.sat = 1'b1;
            end
        end

        if (last && formula_phase < PHASE_FINAL)
            formula_phase = formula_phase + PHASE_W'(1);

        r.index = idx;
        r.value = nxt[VALUE_W-1:0];
        r.ntime = t + dt;
        r.last  = last;
        return r;
    endfunction

    // Result checker: every output transfer is matched with the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_predicted_state p;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (predicted_states.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transfer, index %0d value %0d",
                         $time, o_out_index, o_next_value);
            end else begin
                p = predicted_states.pop_front();
                if (o_out_index !== p.index) begin
                    mismatch_count++;
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, p.index, o_out_index);
                end
                if (o_next_value !== p.value) begin
                    mismatch_count++;
                    $display("%0t: next_value (index %0d) expected %0d actual %0d",
                             $time, p.index, p.value, o_next_value);
                end
                if (o_next_time !== p.ntime) begin
                    mismatch_count++;
                    $display("%0t: next_time (index %0d) expected %h actual %h",
                             $time, p.index, p.ntime, o_next_time);
                end
                if (o_out_last !== p.last) begin
                    mismatch_count++;
                    $display("%0t: out_last (index %0d) expected %b actual %b",
                             $time, p.index, p.last, o_out_last);
                end
                if (o_saturated !== p.sat) begin
                    mismatch_count++;
                    $display("%0t: saturated (index %0d) expected %b actual %b",
                             $time, p.index, p.sat, o_saturated);
                end
            end
        end
    end

    // Sends one element. The optional gap lowers valid first; without a gap
    // valid stays high straight into the next transfer.
    task automatic send_item(input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] y,
                             input logic [VALUE_W-1:0] yp,
                             input logic [TIME_W-1:0]  t,
                             input logic               last);
        int gap;
        gap = src_steady ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_index <= idx;
        in_value <= y;
        in_deriv <= yp;
        in_time  <= t;
        in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predicted_states.push_back(integrate_item(idx, y, yp, t, last));
        items_sent++;
    endtask

    // Drops valid and waits until every result is back and the pipe is empty.
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (predicted_states.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write over the configuration channel; only called while idle.
    task automatic write_register(input t_cfg_reg reg_id, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_id;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (reg_id == CFG_STEP_LEN)
            cur_step = data[STEP_W-1:0];
        else
            cur_vlen = data[VLEN_W-1:0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Signed Q16.16 value: mostly moderate magnitudes so that not every
    // result saturates, plus the range ends and fully random words.
    function automatic logic [VALUE_W-1:0] rand_q16();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 32'h80000)) - 32'sh40000;
            4, 5, 6:    v = int'($urandom_range(0, 32'h2000000)) - 32'sh1000000;
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom);
        endcase
        return v;
    endfunction

    // Time stamp, sometimes just short of the 48-bit wrap.
    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 32'h3FFFF));
        return w[TIME_W-1:0];
    endfunction

    // Step length word; the unused top bit of the data word is randomized too.
    function automatic logic [CFG_DATA_W-1:0] rand_step();
        logic [STEP_W-1:0] h;
        case ($urandom_range(0, 7))
            0:       h = STEP_RESET;
            1, 2, 3: h = STEP_W'($urandom_range(1024, 262144));
            4:       h = STEP_W'($urandom);
            5:       h = '0;
            6:       h = {STEP_W{1'b1}};
            default: h = STEP_W'($urandom_range(1, 16));
        endcase
        return {1'($urandom_range(0, 1)), h};
    endfunction

    // One vector of elements 0..len-1 in shuffled order, last marker on the
    // final one. With noise on, stray out-of-range or repeated elements are
    // mixed in and the last marker is occasionally left off.
    task automatic send_vector(input int len, input bit noisy);
        int order[MAX_ELEMENTS];
        int j, tmp, k;
        logic [TIME_W-1:0] t;
        logic mark;
        for (k = 0; k < len; k++)
            order[k] = k;
        for (k = len - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        t = rand_time();
        for (k = 0; k < len; k++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                if (cur_vlen < VLEN_W'(MAX_ELEMENTS))
                    send_item(INDEX_W'($urandom_range(cur_vlen, MAX_ELEMENTS - 1)),
                              rand_q16(), rand_q16(), t, $urandom_range(0, 7) == 0);
                else
                    send_item(INDEX_W'($urandom_range(0, MAX_ELEMENTS - 1)),
                              rand_q16(), rand_q16(), t, 1'b0);
            end
            mark = (k == len - 1);
            if (noisy && mark && $urandom_range(0, 15) == 0)
                mark = 1'b0;
            send_item(INDEX_W'(order[k]), rand_q16(), rand_q16(), t, mark);
        end
    endtask

    task automatic pick_pacing();
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Reset defaults: step 1.0 and vector length one, still in the Euler
    // phase. Element 0 is in range, the others pass through untouched. No
    // last marker, so the phase does not move.
    task automatic test_reset_values();
        send_item(4'd0,  32'h8000_0000, 32'h7FFF_FFFF, {TIME_W{1'b1}}, 1'b0);
        send_item(4'd15, 32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b0);
        send_item(4'd1,  32'hFFFF_FFFF, 32'h0000_0001, rand_time(), 1'b0);
        send_item(4'd8,  rand_q16(), rand_q16(), rand_time(), 1'b0);
    endtask

    // Full starter with all sixteen elements so that every history slot is
    // written before anything reads it: Euler, AB2, two quarter AB3 steps,
    // two half AB3 steps and the first full AB3 step. Each phase runs under a
    // different step length, the range ends among them.
    task automatic test_starter_phases();
        int p;
        wait_idle();
        write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(MAX_ELEMENTS));
        for (p = 0; p < 7; p++) begin
            wait_idle();
            case (p)
                0:       write_register(CFG_STEP_LEN, CFG_DATA_W'(STEP_RESET));
                2:       write_register(CFG_STEP_LEN, 32'h7FFF_FFFF);
                4:       write_register(CFG_STEP_LEN, 32'h8000_0000);
                default: write_register(CFG_STEP_LEN, CFG_DATA_W'($urandom_range(4096, 200000)));
            endcase
            pick_pacing();
            send_vector(MAX_ELEMENTS, 1'b0);
        end
    endtask

    // Value extremes at full step: saturation both ways, zero step, time wrap
    // and the shortest vector with an out-of-range element carrying last.
    task automatic test_extreme_values();
        wait_idle();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        write_register(CFG_STEP_LEN, 32'hFFFF_FFFF);
        send_item(4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, rand_time(), 1'b0);
        send_item(4'd1, 32'h8000_0000, 32'h8000_0000, rand_time(), 1'b0);
        send_item(4'd2, 32'h0000_0000, 32'h0000_0000, {TIME_W{1'b1}}, 1'b0);
        send_item(4'd3, 32'h7FFF_FFFF, 32'h0000_0001, {TIME_W{1'b1}}, 1'b1);
        wait_idle();
        write_register(CFG_STEP_LEN, 32'h0000_0001);
        send_item(4'd4, 32'h0000_0000, 32'hFFFF_FFFF, rand_time(), 1'b0);
        send_item(4'd5, 32'h8000_0000, 32'h8000_0000, rand_time(), 1'b1);
        wait_idle();
        write_register(CFG_STEP_LEN, 32'h0000_0000);
        send_item(4'd6, 32'h1234_5678, 32'h8000_0000, rand_time(), 1'b0);
        wait_idle();
        write_register(CFG_VECTOR_LENGTH, 32'd1);
        write_register(CFG_STEP_LEN, CFG_DATA_W'(STEP_RESET));
        send_item(4'd15, 32'h8000_0000, 32'h7FFF_FFFF, rand_time(), 1'b1);
        send_item(4'd0,  rand_q16(), rand_q16(), rand_time(), 1'b1);
    endtask

    // Random vectors at full step. Each setting draws a vector length (the
    // ends favored) and a step length, then a run of noisy vectors.
    task automatic test_random_vectors();
        int len;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       len = 1;
                1:       len = MAX_ELEMENTS;
                default: len = $urandom_range(1, MAX_ELEMENTS);
            endcase
            write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(len));
            write_register(CFG_STEP_LEN, rand_step());
            pick_pacing();
            repeat ($urandom_range(3, 12)) send_vector(len, 1'b1);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_starter_phases();
        test_extreme_values();
        test_random_vectors();

        // Drain: all results back, then an extra wait for strays.
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (predicted_states.size() != 0) @(posedge i_clk);
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("adams_bashforth3_integrator_core verification clean");
        else
            $display("adams_bashforth3_integrator_core verification failed");
        $finish;
    end

endmodule
